FILE: rtl/sru_pkg.sv
// Shared types and constants for the shift and rotate unit.
package sru_pkg;

    // Operation kinds as carried on the request tuser.
    typedef enum logic [1:0] {
        KIND_ASX  = 2'd0,  // arithmetic shift
        KIND_LSX  = 2'd1,  // logical shift
        KIND_ROXX = 2'd2,  // rotate through extend
        KIND_ROX  = 2'd3   // plain rotate
    } t_kind;

    // Operand size codes; the unused code behaves as long.
    localparam logic [1:0] OPSZ_8  = 2'd0;
    localparam logic [1:0] OPSZ_16 = 2'd1;
    localparam logic [1:0] OPSZ_32 = 2'd2;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int AMT_W    = 6;   // holds widths up to 33
    localparam int IN_USER_W  = 8; // kind, shift_left, size -> 5 bits, padded
    localparam int IN_DATA_W  = 40; // operand, count, extend_in -> 39 bits, padded
    localparam int OUT_DATA_W = 40; // result, five flags -> 37 bits, padded

    // Sized width in bits for a size code.
    function automatic logic [AMT_W-1:0] size_width(input logic [1:0] size);
        logic [AMT_W-1:0] w;
        case (size)
            OPSZ_8:  w = 6'd8;
            OPSZ_16: w = 6'd16;
            default: w = 6'd32;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/shift_rotate_unit.sv
// Top level: 68000-style shift and rotate unit with flag generation.
//
//  channel   dir  tdata (low bit up)                          tuser (low bit up)
//  -------   ---  ------------------------------------------  ----------------------------
//  s_axis    in   operand[31:0] count[37:32] extend_in[38]    kind[1:0] shift_left[2]
//                                                              size[4:3]
//  m_axis    out  result[31:0] flag_x[32] flag_n[33]           -
//                 flag_z[34] flag_v[35] flag_c[36]
//
// Two register stages: the request register, then the result register, with the
// barrel shifters, ring rotators and flag logic between them. One request is taken
// every cycle as long as the result side keeps taking.
// A stalled result stage holds its data; the request stage still accepts while
// it is empty or moving forward, so ready falls only when both stages are full.
// Reset (i_rst_n low, synchronous) empties both stages; payloads are not cleared.
module shift_rotate_unit
    import sru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request: operand[31:0] count[37:32] extend_in[38], zero pad above
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // request: kind[1:0] shift_left[2] size[4:3], zero pad above
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // result: result[31:0] flag_x[32] flag_n[33] flag_z[34] flag_v[35] flag_c[36]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready
);

    // ---------------- request register ----------------
    logic               r_in_vld;
    t_kind              r_kind;
    logic               r_left;
    logic [1:0]         r_size;
    logic [DATA_W-1:0]  r_operand;
    logic [COUNT_W-1:0] r_count;
    logic               r_xin;

    // ---------------- result register ----------------
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic adv_out;   // result stage can load this cycle
    logic s_ready;

    assign adv_out = !r_out_vld || i_m_axis_tready;
    assign s_ready = !r_in_vld || adv_out;

    // Rotate an n-bit ring (n <= 33) by r (r < n) in either direction.
    function automatic logic [DATA_W:0] ring_rot(input logic [DATA_W:0]  ring,
                                                  input logic [AMT_W-1:0] n,
                                                  input logic [AMT_W-1:0] r,
                                                  input logic             left);
        logic [DATA_W:0]  nmask;
        logic [AMT_W-1:0] sh;
        logic [DATA_W:0]  res;
        nmask = ~({(DATA_W+1){1'b1}} << n);
        sh    = n - r;
        if (left) begin
            res = (ring << r) | (ring >> sh);
        end else begin
            res = (ring >> r) | (ring << sh);
        end
        return res & nmask;
    endfunction

    // ---------------- execute logic ----------------
    logic [AMT_W-1:0]   w;         // operand width in bits
    logic [AMT_W-1:0]   w1;        // ring width for rotate through extend
    logic [AMT_W-2:0]   msb_idx;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  val;
    logic               sign;
    logic [2*DATA_W-1:0] z64;
    logic [2*DATA_W-1:0] s64;
    logic [2*DATA_W-1:0] lsl;
    logic [2*DATA_W-1:0] lsr;
    logic [2*DATA_W-1:0] asr;
    logic [2*DATA_W-1:0] top;      // operand aligned to bit 63, for overflow
    logic [2*DATA_W-1:0] win;      // top count+1 bits
    logic [COUNT_W-1:0]  cm1;
    logic                cnt_nz;
    logic [AMT_W-1:0]    rot_amt;
    logic [AMT_W-1:0]    rox_amt;
    logic [DATA_W:0]     rot_res;
    logic [DATA_W:0]     rox_ring;
    logic [DATA_W:0]     rox_res;
    logic [DATA_W-1:0]   res;
    logic                fx, fn, fz, fv, fc;

    always_comb begin
        w       = size_width(r_size);
        w1      = w + 6'd1;
        msb_idx = 5'(w - 6'd1);
        mask    = ~({DATA_W{1'b1}} << w[AMT_W-1:0]) | ((w == 6'd32) ? {DATA_W{1'b1}} : '0);
        val     = r_operand & mask;
        sign    = val[msb_idx];
        cnt_nz  = (r_count != '0);
        cm1     = r_count - 6'd1;

        z64 = {{DATA_W{1'b0}}, val};
        s64 = {{DATA_W{sign}}, val | (sign ? ~mask : '0)};
        lsl = z64 << r_count;
        lsr = z64 >> r_count;
        asr = $unsigned($signed(s64) >>> r_count);

        // V: some step changed the MSB, i.e. the top count+1 bits (zeros
        // shifted in below the operand) are not all equal.
        top = {val << (6'd32 - w), {DATA_W{1'b0}}};
        win = top & ~({(2*DATA_W){1'b1}} >> ({1'b0, r_count} + 7'd1));

        // plain rotate: width is a power of two
        rot_amt = r_count & (w - 6'd1);
        rot_res = ring_rot({1'b0, val}, w, rot_amt, r_left);

        // rotate through extend: count modulo width+1, seven side-by-side
        // compares against multiples of the ring width, largest match wins
        rox_amt = r_count;
        for (int k = 1; k < 8; k++) begin
            if ({2'b00, r_count} >= 8'(k) * {2'b00, w1}) begin
                rox_amt = 6'({2'b00, r_count} - 8'(k) * {2'b00, w1});
            end
        end
        rox_ring = {1'b0, val} | ((DATA_W+1)'(r_xin) << w);
        rox_res  = ring_rot(rox_ring, w1, rox_amt, r_left);

        res = '0;
        fx  = r_xin;
        fv  = 1'b0;
        fc  = 1'b0;
        unique case (r_kind) inside
            KIND_ASX, KIND_LSX: begin
                if (r_left) begin
                    res = lsl[DATA_W-1:0] & mask;
                    fc  = cnt_nz & lsl[w];
                    if (r_kind == KIND_ASX) begin
                        fv = (win != '0) &&
                             (win != ~({(2*DATA_W){1'b1}} >> ({1'b0, r_count} + 7'd1)));
                    end
                end else if (r_kind == KIND_ASX) begin
                    res = asr[DATA_W-1:0] & mask;
                    fc  = cnt_nz & s64[cm1];
                end else begin
                    res = lsr[DATA_W-1:0];
                    fc  = cnt_nz & z64[cm1];
                end
                fx = cnt_nz ? fc : r_xin;
            end
            KIND_ROXX: begin
                res = rox_res[DATA_W-1:0] & mask;
                fx  = rox_res[w];
                fc  = rox_res[w];
            end
            KIND_ROX: begin
                res = rot_res[DATA_W-1:0];
                fc  = cnt_nz & (r_left ? res[0] : res[msb_idx]);
            end
        endcase
        fn = res[msb_idx];
        fz = (res == '0);
    end

    // ---------------- stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_ready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (adv_out) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_axis_tvalid) begin
            r_kind    <= t_kind'(i_s_axis_tuser[1:0]);
            r_left    <= i_s_axis_tuser[2];
            r_size    <= i_s_axis_tuser[4:3];
            r_operand <= i_s_axis_tdata[31:0];
            r_count   <= i_s_axis_tdata[37:32];
            r_xin     <= i_s_axis_tdata[38];
        end
        if (adv_out && r_in_vld) begin
            r_out_data <= {3'b000, fc, fv, fz, fn, fx, res};
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // A request in the first stage moves to the result stage when it is free.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv_out |=> o_m_axis_tvalid)
        else $error("request lost between stages");

    // Ready drops only when both stages hold requests.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_vld && r_out_vld)
        else $error("ready low with a free stage");

    // Z flag agrees with the delivered result.
    a_zflag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[34] == (o_m_axis_tdata[31:0] == '0))
        else $error("Z flag disagrees with result");

endmodule
